// ===== sv/hoer_pkg.sv =====
// shared types, codes and the microcode table of the hex object record encoder
`timescale 1ns / 1ps

package hoer_pkg;

    localparam int PC_W = 7;
    typedef logic [PC_W-1:0] pc_t;

    // output formats
    localparam logic [2:0] FMT_INTEL = 3'd0;
    localparam logic [2:0] FMT_MOS   = 3'd1;
    localparam logic [2:0] FMT_MOTO  = 3'd2;
    localparam logic [2:0] FMT_BIN   = 3'd3;
    localparam logic [2:0] FMT_IWORD = 3'd4;

    // configuration register indexes
    localparam logic REG_FORMAT       = 1'b0;
    localparam logic REG_RECORD_BYTES = 1'b1;

    // microword kinds
    localparam logic [1:0] K_LIT = 2'd0;
    localparam logic [1:0] K_HEX = 2'd1;
    localparam logic [1:0] K_RAW = 2'd2;

    // hex value sources
    localparam logic [2:0] SEL_CNT  = 3'd0;
    localparam logic [2:0] SEL_CNT3 = 3'd1;
    localparam logic [2:0] SEL_ADDR = 3'd2;
    localparam logic [2:0] SEL_SUM  = 3'd3;
    localparam logic [2:0] SEL_CKI  = 3'd4;
    localparam logic [2:0] SEL_CKM  = 3'd5;
    localparam logic [2:0] SEL_CKE  = 3'd6;
    localparam logic [2:0] SEL_BUF  = 3'd7;

    // program entry points
    localparam pc_t EP_INT  = 7'd0;
    localparam pc_t EP_MOS  = 7'd14;
    localparam pc_t EP_MOT  = 7'd28;
    localparam pc_t EP_IEOF = 7'd41;
    localparam pc_t EP_MEOF = 7'd53;
    localparam pc_t EP_SEOF = 7'd57;
    localparam pc_t EP_RAW  = 7'd68;

    // characters
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] lit;
        logic [2:0] sel;
        logic [1:0] nib;
        logic       loop;
        logic       inc;
        logic       fin;
        pc_t        target;
    } ucode_t;

    typedef struct packed {
        logic [7:0]  cnt;
        logic [15:0] addr;
        logic [15:0] sum;
        logic [7:0]  raw;
    } rec_ops_t;

    function automatic ucode_t u_lit(logic [7:0] c, logic fin);
        ucode_t u;
        u = '{kind: K_LIT, lit: c, sel: SEL_CNT, nib: 2'd0, loop: 1'b0, inc: 1'b0,
              fin: fin, target: '0};
        return u;
    endfunction

    function automatic ucode_t u_hex(logic [2:0] sel, logic [1:0] nib);
        ucode_t u;
        u = '{kind: K_HEX, lit: CH_NUL, sel: sel, nib: nib, loop: 1'b0, inc: 1'b0,
              fin: 1'b0, target: '0};
        return u;
    endfunction

    // low digit of a buffered byte, loops back while bytes remain
    function automatic ucode_t u_loop(pc_t target);
        ucode_t u;
        u = '{kind: K_HEX, lit: CH_NUL, sel: SEL_BUF, nib: 2'd0, loop: 1'b1, inc: 1'b1,
              fin: 1'b0, target: target};
        return u;
    endfunction

    function automatic ucode_t ucode_rom(pc_t pc);
        ucode_t u;
        unique case (pc)
            // intel and intel word data record
            7'd0:  u = u_lit(CH_COLON, 1'b0);
            7'd1:  u = u_hex(SEL_CNT, 2'd1);
            7'd2:  u = u_hex(SEL_CNT, 2'd0);
            7'd3:  u = u_hex(SEL_ADDR, 2'd3);
            7'd4:  u = u_hex(SEL_ADDR, 2'd2);
            7'd5:  u = u_hex(SEL_ADDR, 2'd1);
            7'd6:  u = u_hex(SEL_ADDR, 2'd0);
            7'd7:  u = u_lit(CH_0, 1'b0);
            7'd8:  u = u_lit(CH_0, 1'b0);
            7'd9:  u = u_hex(SEL_BUF, 2'd1);
            7'd10: u = u_loop(7'd9);
            7'd11: u = u_hex(SEL_CKI, 2'd1);
            7'd12: u = u_hex(SEL_CKI, 2'd0);
            7'd13: u = u_lit(CH_LF, 1'b1);
            // mos tech data record
            7'd14: u = u_lit(CH_SEMI, 1'b0);
            7'd15: u = u_hex(SEL_CNT, 2'd1);
            7'd16: u = u_hex(SEL_CNT, 2'd0);
            7'd17: u = u_hex(SEL_ADDR, 2'd3);
            7'd18: u = u_hex(SEL_ADDR, 2'd2);
            7'd19: u = u_hex(SEL_ADDR, 2'd1);
            7'd20: u = u_hex(SEL_ADDR, 2'd0);
            7'd21: u = u_hex(SEL_BUF, 2'd1);
            7'd22: u = u_loop(7'd21);
            7'd23: u = u_hex(SEL_SUM, 2'd3);
            7'd24: u = u_hex(SEL_SUM, 2'd2);
            7'd25: u = u_hex(SEL_SUM, 2'd1);
            7'd26: u = u_hex(SEL_SUM, 2'd0);
            7'd27: u = u_lit(CH_LF, 1'b1);
            // motorola s1 record
            7'd28: u = u_lit(CH_S, 1'b0);
            7'd29: u = u_lit(CH_1, 1'b0);
            7'd30: u = u_hex(SEL_CNT3, 2'd1);
            7'd31: u = u_hex(SEL_CNT3, 2'd0);
            7'd32: u = u_hex(SEL_ADDR, 2'd3);
            7'd33: u = u_hex(SEL_ADDR, 2'd2);
            7'd34: u = u_hex(SEL_ADDR, 2'd1);
            7'd35: u = u_hex(SEL_ADDR, 2'd0);
            7'd36: u = u_hex(SEL_BUF, 2'd1);
            7'd37: u = u_loop(7'd36);
            7'd38: u = u_hex(SEL_CKM, 2'd1);
            7'd39: u = u_hex(SEL_CKM, 2'd0);
            7'd40: u = u_lit(CH_LF, 1'b1);
            // intel end record
            7'd41: u = u_lit(CH_COLON, 1'b0);
            7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48:
                   u = u_lit(CH_0, 1'b0);
            7'd49: u = u_lit(CH_1, 1'b0);
            7'd50: u = u_lit(CH_F, 1'b0);
            7'd51: u = u_lit(CH_F, 1'b0);
            7'd52: u = u_lit(CH_LF, 1'b1);
            // mos tech end record
            7'd53: u = u_lit(CH_SEMI, 1'b0);
            7'd54: u = u_lit(CH_0, 1'b0);
            7'd55: u = u_lit(CH_0, 1'b0);
            7'd56: u = u_lit(CH_LF, 1'b1);
            // motorola s9 record
            7'd57: u = u_lit(CH_S, 1'b0);
            7'd58: u = u_lit(CH_9, 1'b0);
            7'd59: u = u_lit(CH_0, 1'b0);
            7'd60: u = u_lit(CH_3, 1'b0);
            7'd61: u = u_hex(SEL_ADDR, 2'd3);
            7'd62: u = u_hex(SEL_ADDR, 2'd2);
            7'd63: u = u_hex(SEL_ADDR, 2'd1);
            7'd64: u = u_hex(SEL_ADDR, 2'd0);
            7'd65: u = u_hex(SEL_CKE, 2'd1);
            7'd66: u = u_hex(SEL_CKE, 2'd0);
            7'd67: u = u_lit(CH_LF, 1'b1);
            // binary pass-through
            7'd68: u = '{kind: K_RAW, lit: CH_NUL, sel: SEL_CNT, nib: 2'd0, loop: 1'b0,
                         inc: 1'b0, fin: 1'b1, target: '0};
            default: u = u_lit(CH_NUL, 1'b1);
        endcase
        return u;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'h0, n};
        end else begin
            c = 8'h37 + {4'h0, n};
        end
        return c;
    endfunction

endpackage

// ===== sv/hex_object_record_encoder.sv =====
// top level: record buffer, configuration and transaction control
// a byte that does not close a record is only buffered; any other item but a binary end
// item starts the microcode sequencer, which registers its characters in an output stage
// and gives one character per cycle while m_tready does not stall it: 2n+12 for an intel
// record of n bytes (2n+12 mos tech, 2n+11 motorola), 12/4/11 for end records
// and 1 in binary; the next item can be taken once the final character is registered
// synchronous reset empties the record, sets intel format and 16-byte records
`timescale 1ns / 1ps

module hex_object_record_encoder #(
    parameter int MAX_RECORD_BYTES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte[7:0], address[23:8], end_address[39:24]
    input  logic        s_tuser,   // op
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast
);

    localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 1);
    localparam int IDX_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

    logic [2:0]         format_reg, format_next;
    logic [4:0]         record_bytes_reg, record_bytes_next;
    logic [CNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [15:0]        record_address_reg, record_address_next;
    logic [15:0]        running_sum_reg, running_sum_next;
    hoer_pkg::rec_ops_t ops_reg, ops_next;
    logic [7:0]         record_buffer [MAX_RECORD_BYTES];

    logic               in_op;
    logic [7:0]         in_data;
    logic [15:0]        in_address;
    logic [15:0]        in_end_address;
    logic               accept;
    logic               fmt_ok;
    logic [CNT_W-1:0]   limit;
    logic               has_room;
    logic [CNT_W-1:0]   count_new;
    logic [15:0]        sum_new;
    logic [15:0]        addr_new;
    logic               close_rec;
    logic               buf_we;
    logic               start;
    hoer_pkg::pc_t      entry;
    logic [IDX_W-1:0]   buf_idx;
    logic [7:0]         buf_byte;
    logic               busy;

    assign in_op          = s_tuser;
    assign in_data        = s_tdata[7:0];
    assign in_address     = s_tdata[23:8];
    assign in_end_address = s_tdata[39:24];

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;
    assign accept    = s_tvalid && s_tready;
    assign fmt_ok    = format_reg <= hoer_pkg::FMT_IWORD;

    always_comb begin
        priority if (record_bytes_reg == 5'd0) begin
            limit = CNT_W'(1);
        end else if (record_bytes_reg > 5'(MAX_RECORD_BYTES)) begin
            limit = CNT_W'(MAX_RECORD_BYTES);
        end else begin
            limit = CNT_W'(record_bytes_reg);
        end
    end

    assign has_room  = byte_count_reg < CNT_W'(MAX_RECORD_BYTES);
    assign count_new = has_room ? byte_count_reg + CNT_W'(1) : byte_count_reg;
    assign sum_new   = has_room ? running_sum_reg + 16'(in_data) : running_sum_reg;
    assign addr_new  = (byte_count_reg == '0) ? in_address : record_address_reg;
    assign close_rec = (count_new >= limit) || s_tlast;

    always_comb begin
        format_next       = format_reg;
        record_bytes_next = record_bytes_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                hoer_pkg::REG_FORMAT:       format_next = cfg_data[2:0];
                hoer_pkg::REG_RECORD_BYTES: record_bytes_next = cfg_data;
                default:                    format_next = format_reg;
            endcase
        end
    end

    always_comb begin
        byte_count_next     = byte_count_reg;
        record_address_next = record_address_reg;
        running_sum_next    = running_sum_reg;
        ops_next            = ops_reg;
        buf_we              = 1'b0;
        start               = 1'b0;
        entry               = hoer_pkg::EP_RAW;
        if (accept && fmt_ok) begin
            priority if (in_op) begin
                ops_next.addr = in_end_address;
                unique case (format_reg)
                    hoer_pkg::FMT_MOS: begin
                        start = 1'b1;
                        entry = hoer_pkg::EP_MEOF;
                    end
                    hoer_pkg::FMT_MOTO: begin
                        start = 1'b1;
                        entry = hoer_pkg::EP_SEOF;
                    end
                    hoer_pkg::FMT_BIN: begin
                        start = 1'b0;
                    end
                    default: begin
                        start = 1'b1;
                        entry = hoer_pkg::EP_IEOF;
                    end
                endcase
            end else if (format_reg == hoer_pkg::FMT_BIN) begin
                start        = 1'b1;
                entry        = hoer_pkg::EP_RAW;
                ops_next.raw = in_data;
            end else begin
                buf_we              = has_room;
                record_address_next = addr_new;
                if (close_rec) begin
                    start            = 1'b1;
                    ops_next.cnt     = 8'(count_new);
                    ops_next.sum     = sum_new;
                    ops_next.addr    = (format_reg == hoer_pkg::FMT_IWORD) ?
                                       {1'b0, addr_new[15:1]} : addr_new;
                    byte_count_next  = '0;
                    running_sum_next = 16'h0000;
                    unique case (format_reg)
                        hoer_pkg::FMT_MOS:  entry = hoer_pkg::EP_MOS;
                        hoer_pkg::FMT_MOTO: entry = hoer_pkg::EP_MOT;
                        default:            entry = hoer_pkg::EP_INT;
                    endcase
                end else begin
                    byte_count_next  = count_new;
                    running_sum_next = sum_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg         <= hoer_pkg::FMT_INTEL;
            record_bytes_reg   <= 5'd16;
            byte_count_reg     <= '0;
            record_address_reg <= 16'h0000;
            running_sum_reg    <= 16'h0000;
        end else begin
            format_reg         <= format_next;
            record_bytes_reg   <= record_bytes_next;
            byte_count_reg     <= byte_count_next;
            record_address_reg <= record_address_next;
            running_sum_reg    <= running_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        ops_reg <= ops_next;
        if (buf_we) begin
            record_buffer[byte_count_reg[IDX_W-1:0]] <= in_data;
        end
        buf_byte <= record_buffer[buf_idx];
    end

    hoer_sequencer #(
        .IDX_W(IDX_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .entry    (entry),
        .ops      (ops_next),
        .buf_idx  (buf_idx),
        .buf_byte (buf_byte),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= CNT_W'(MAX_RECORD_BYTES))
        else $error("record byte count beyond buffer depth");

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && !in_op && format_reg != hoer_pkg::FMT_BIN) |=>
        (byte_count_reg == '0 && running_sum_reg == 16'h0000))
        else $error("closed record left bytes buffered");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (busy && !s_tready))
        else $error("sequencer not busy after record start");
`endif

endmodule

// ===== sv/hoer_sequencer.sv =====
// microcoded character sequencer with registered output stage
`timescale 1ns / 1ps

module hoer_sequencer #(
    parameter int IDX_W = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  hoer_pkg::pc_t       entry,
    input  hoer_pkg::rec_ops_t  ops,
    output logic [IDX_W-1:0]    buf_idx,
    input  logic [7:0]          buf_byte,
    output logic                busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // out_byte[7:0]
    output logic                m_tlast
);

    hoer_pkg::pc_t    pc_reg, pc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg, m_tlast_next;

    hoer_pkg::ucode_t uw;
    logic             step;
    logic             more;
    logic [15:0]      sum16;
    logic [7:0]       ck_eof;
    logic [15:0]      val;
    logic [3:0]       nibble;
    logic [7:0]       chr;

    assign uw     = hoer_pkg::ucode_rom(pc_reg);
    assign step   = busy_reg && (!m_tvalid_reg || m_tready);
    assign more   = (8'(idx_reg) + 8'd1) != ops.cnt;
    assign sum16  = 16'(ops.cnt) + 16'(ops.addr[15:8]) + 16'(ops.addr[7:0]) + ops.sum;
    assign ck_eof = ~(8'd3 + ops.addr[15:8] + ops.addr[7:0]);

    always_comb begin
        unique case (uw.sel)
            hoer_pkg::SEL_CNT:  val = {8'h00, ops.cnt};
            hoer_pkg::SEL_CNT3: val = {8'h00, ops.cnt + 8'd3};
            hoer_pkg::SEL_ADDR: val = ops.addr;
            hoer_pkg::SEL_SUM:  val = sum16;
            hoer_pkg::SEL_CKI:  val = {8'h00, 8'h00 - sum16[7:0]};
            hoer_pkg::SEL_CKM:  val = {8'h00, ~(sum16[7:0] + 8'd3)};
            hoer_pkg::SEL_CKE:  val = {8'h00, ck_eof};
            hoer_pkg::SEL_BUF:  val = {8'h00, buf_byte};
            default:            val = 16'h0000;
        endcase
    end

    always_comb begin
        unique case (uw.nib)
            2'd0:    nibble = val[3:0];
            2'd1:    nibble = val[7:4];
            2'd2:    nibble = val[11:8];
            2'd3:    nibble = val[15:12];
            default: nibble = val[3:0];
        endcase
    end

    always_comb begin
        unique case (uw.kind)
            hoer_pkg::K_LIT: chr = uw.lit;
            hoer_pkg::K_HEX: chr = hoer_pkg::hex_char(nibble);
            hoer_pkg::K_RAW: chr = ops.raw;
            default:         chr = uw.lit;
        endcase
    end

    always_comb begin
        pc_next       = pc_reg;
        idx_next      = idx_reg;
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (start) begin
            pc_next   = entry;
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (step) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = chr;
            m_tlast_next  = uw.fin;
            if (uw.fin) begin
                busy_next = 1'b0;
            end else if (uw.loop && more) begin
                pc_next = uw.target;
            end else begin
                pc_next = pc_reg + hoer_pkg::PC_W'(1);
            end
            if (uw.inc) begin
                idx_next = more ? idx_reg + IDX_W'(1) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            idx_reg      <= '0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            idx_reg      <= idx_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    // read address is the next index, so the registered buffer read matches the current index
    assign buf_idx  = idx_next;
    assign busy     = busy_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
